// ===== sv/stod_pkg.sv =====
// ----------------------------------------------------------------------------
// Settable time-of-day clock package
// Shared types, opcodes and constants for the time-of-day clock.
// ----------------------------------------------------------------------------
package stod_pkg;

   localparam int MS_WIDTH_DEFAULT = 32;

   localparam int OPCODE_W   = 3;
   localparam int NOW_W      = 32;
   localparam int HOUR_W     = 5;
   localparam int MIN_W      = 6;
   localparam int SEC_W      = 6;
   localparam int DAYSEC_W   = 17;
   localparam int FIELD_W    = 2;
   localparam int INTERVAL_W = 16;

   localparam logic [INTERVAL_W-1:0] BLINK_INTERVAL_RESET = 16'd500;

   // opcodes
   localparam logic [OPCODE_W-1:0] OP_TICK    = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_NEXT    = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_INC     = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_DEC     = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_DISPLAY = 3'd4;

   // edit field codes
   localparam logic [FIELD_W-1:0] FLD_HOURS   = 2'd0;
   localparam logic [FIELD_W-1:0] FLD_MINUTES = 2'd1;
   localparam logic [FIELD_W-1:0] FLD_SECONDS = 2'd2;
   localparam logic [FIELD_W-1:0] FLD_AMPM    = 2'd3;

   // blank codes
   localparam logic [FIELD_W-1:0] BLANK_NONE = 2'd0;

   localparam logic [HOUR_W-1:0] HOUR_MAX  = 5'd23;
   localparam logic [HOUR_W-1:0] HALF_DAY  = 5'd12;
   localparam logic [MIN_W-1:0]  MIN_MAX   = 6'd59;
   localparam logic [SEC_W-1:0]  SEC_MAX   = 6'd59;

   localparam logic [DAYSEC_W-1:0] SEC_PER_HOUR = 17'd3600;
   localparam logic [DAYSEC_W-1:0] SEC_PER_MIN  = 17'd60;

   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic                editing;
      logic [NOW_W-1:0]    now_ms;
   } req_type;

   typedef struct packed {
      logic [HOUR_W-1:0]   hours_out;
      logic [MIN_W-1:0]    minutes_out;
      logic [SEC_W-1:0]    seconds_out;
      logic [DAYSEC_W-1:0] day_seconds;
      logic [FIELD_W-1:0]  blank_field;
      logic                blink_phase;
      logic [FIELD_W-1:0]  edit_field;
   } rsp_type;

endpackage

// ===== sv/stod_req_if.sv =====
// ----------------------------------------------------------------------------
// Time-of-day clock request channel
// Valid/ready channel carrying one command item.
// ----------------------------------------------------------------------------
interface stod_req_if
   import stod_pkg::*;
   ;
   logic    valid;
   logic    ready;
   req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/stod_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Time-of-day clock response channel
// Valid/ready channel carrying one time report.
// ----------------------------------------------------------------------------
interface stod_rsp_if
   import stod_pkg::*;
   ;
   logic    valid;
   logic    ready;
   rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/settable_time_of_day_clock.sv =====
// ----------------------------------------------------------------------------
// Settable time-of-day clock
// Hours/minutes/seconds clock with tick, edit and blinking display commands.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one command per transfer (opcode, editing, now_ms).
//   rsp_ch returns exactly one report per command: the time after the
//   update, the seconds of the day, the blank code, blink phase and the
//   selected edit field.
//   csr_we/csr_wdata write the blink interval in milliseconds; write it only
//   while no command is in flight.
//   A request transfer passes through one input register, then the state
//   update and the response register, before its response can transfer;
//   rsp_ch.valid rises once the response register is loaded.
//   Throughput is one command per cycle while rsp_ch does not stall; the
//   state update is a single short pass of counter and compare logic.
//   The response register is full while the input register is held, so up
//   to two commands sit in the block when rsp_ch stalls; req_ch.ready drops
//   only when both are full and the receiver is not ready.
//   Reset clears the time to 00:00:00, the field select to hours, the blink
//   flag to the blank phase, the last toggle time to 0 and the interval to
//   500 ms.
// ----------------------------------------------------------------------------
module settable_time_of_day_clock
   import stod_pkg::*;
#(
   parameter int MS_WIDTH = MS_WIDTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   stod_req_if.sink              req_ch,
   stod_rsp_if.source            rsp_ch,
   input  logic                  csr_we,
   input  logic [INTERVAL_W-1:0] csr_wdata
);

   logic                  s1_valid_ff;
   req_type               s1_item_ff;
   logic                  rsp_valid_ff;
   rsp_type               rsp_data_ff;

   logic [INTERVAL_W-1:0] interval_ff;
   logic [HOUR_W-1:0]     hour_ff,        hour_in;
   logic [MIN_W-1:0]      minute_ff,      minute_in;
   logic [SEC_W-1:0]      second_ff,      second_in;
   logic [FIELD_W-1:0]    field_ff,       field_in;
   logic                  blink_ff,       blink_in;
   logic [MS_WIDTH-1:0]   last_toggle_ff, last_toggle_in;

   logic                  out_free;
   logic                  s1_fire;
   logic [MS_WIDTH-1:0]   now_w;
   logic [MS_WIDTH-1:0]   elapsed;
   logic [FIELD_W-1:0]    blank;
   rsp_type               rsp_in;

   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign s1_fire      = s1_valid_ff && out_free;
   assign req_ch.ready = !s1_valid_ff || out_free;

   assign now_w   = MS_WIDTH'(s1_item_ff.now_ms);
   assign elapsed = now_w - last_toggle_ff;

   always_comb begin
      hour_in        = hour_ff;
      minute_in      = minute_ff;
      second_in      = second_ff;
      field_in       = field_ff;
      blink_in       = blink_ff;
      last_toggle_in = last_toggle_ff;
      blank          = BLANK_NONE;

      case (s1_item_ff.opcode) inside
         OP_TICK: begin
            if (second_ff == SEC_MAX) begin
               second_in = '0;
               if (minute_ff == MIN_MAX) begin
                  minute_in = '0;
                  hour_in   = (hour_ff == HOUR_MAX) ? '0 : hour_ff + 1'b1;
               end else begin
                  minute_in = minute_ff + 1'b1;
               end
            end else begin
               second_in = second_ff + 1'b1;
            end
         end
         OP_NEXT: begin
            field_in = field_ff + 1'b1;
         end
         OP_INC, OP_DEC: begin
            if (s1_item_ff.editing) begin
               case (field_ff)
                  FLD_HOURS: begin
                     if (s1_item_ff.opcode == OP_INC) begin
                        hour_in = (hour_ff == HOUR_MAX) ? '0 : hour_ff + 1'b1;
                     end else begin
                        hour_in = (hour_ff == '0) ? HOUR_MAX : hour_ff - 1'b1;
                     end
                  end
                  FLD_MINUTES: begin
                     if (s1_item_ff.opcode == OP_INC) begin
                        minute_in = (minute_ff == MIN_MAX) ? '0 : minute_ff + 1'b1;
                     end else begin
                        minute_in = (minute_ff == '0) ? MIN_MAX : minute_ff - 1'b1;
                     end
                  end
                  FLD_SECONDS: begin
                     if (s1_item_ff.opcode == OP_INC) begin
                        second_in = (second_ff == SEC_MAX) ? '0 : second_ff + 1'b1;
                     end else begin
                        second_in = (second_ff == '0) ? SEC_MAX : second_ff - 1'b1;
                     end
                  end
                  default: begin
                     // swap half of the day; noon wraps to midnight
                     if (hour_ff == HALF_DAY) begin
                        hour_in = '0;
                     end else if (hour_ff < HALF_DAY) begin
                        hour_in = hour_ff + HALF_DAY;
                     end else begin
                        hour_in = hour_ff - HALF_DAY;
                     end
                  end
               endcase
            end
         end
         OP_DISPLAY: begin
            if (s1_item_ff.editing) begin
               if (elapsed > MS_WIDTH'(interval_ff)) begin
                  blink_in       = !blink_ff;
                  last_toggle_in = now_w;
               end
               if (blink_in && field_ff != FLD_AMPM) begin
                  blank = field_ff + 1'b1;
               end
            end
         end
         default: begin
         end
      endcase

      rsp_in.hours_out   = hour_in;
      rsp_in.minutes_out = minute_in;
      rsp_in.seconds_out = second_in;
      rsp_in.day_seconds = DAYSEC_W'(hour_in) * SEC_PER_HOUR
                         + DAYSEC_W'(minute_in) * SEC_PER_MIN
                         + DAYSEC_W'(second_in);
      rsp_in.blank_field = blank;
      rsp_in.blink_phase = blink_in;
      rsp_in.edit_field  = field_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         interval_ff    <= BLINK_INTERVAL_RESET;
         hour_ff        <= '0;
         minute_ff      <= '0;
         second_ff      <= '0;
         field_ff       <= FLD_HOURS;
         blink_ff       <= 1'b1;
         last_toggle_ff <= '0;
      end else begin
         if (csr_we) begin
            interval_ff <= csr_wdata;
         end
         if (req_ch.ready) begin
            s1_valid_ff <= req_ch.valid;
         end
         if (out_free) begin
            rsp_valid_ff <= s1_valid_ff;
         end
         // advance the clock state only when the item moves to the output
         if (s1_fire) begin
            hour_ff        <= hour_in;
            minute_ff      <= minute_in;
            second_ff      <= second_in;
            field_ff       <= field_in;
            blink_ff       <= blink_in;
            last_toggle_ff <= last_toggle_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         s1_item_ff <= req_ch.payload;
      end
      if (s1_fire) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_data_ff;

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Settable time-of-day clock regression
// Drives commands through the valid/ready request channel and checks every
// time report against a cycle-free model of the clock. Directed tests cover
// edits, the day wrap, the half-day swap, the blink window and the spare
// opcodes. Random traffic then runs under several blink intervals while the
// sender bursts and the receiver stalls.
// ----------------------------------------------------------------------------
module testbench
   import stod_pkg::*;
   ;

   localparam int unsigned IDLE_LIMIT    = 2000;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned OPCODE_TOP    = (1 << OPCODE_W) - 1;

   typedef enum logic [1:0] {RX_OPEN, RX_SPOTTY, RX_BURSTY} rx_mode_type;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  csr_we    = 1'b0;
   logic [INTERVAL_W-1:0] csr_wdata = '0;

   stod_req_if req_if ();
   stod_rsp_if rsp_if ();

   settable_time_of_day_clock i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // clock model state
   logic [HOUR_W-1:0]     hour_q        = '0;
   logic [MIN_W-1:0]      minute_q      = '0;
   logic [SEC_W-1:0]      second_q      = '0;
   logic [FIELD_W-1:0]    field_q       = FLD_HOURS;
   logic                  blink_q       = 1'b1;
   logic [NOW_W-1:0]      last_toggle_q = '0;
   logic [INTERVAL_W-1:0] interval_q    = BLINK_INTERVAL_RESET;

   rsp_type     expected_reports[$];
   rsp_type     want_report;
   int unsigned error_count     = 0;
   int unsigned commands_sent   = 0;
   int unsigned reports_checked = 0;
   int unsigned toggles_seen    = 0;
   int unsigned settings_used   = 0;
   bit          in_session      = 1'b0;
   logic [NOW_W-1:0] wall_ms    = '0;

   function automatic rsp_type predict_time_report(input req_type cmd);
      rsp_type     rpt;
      logic [NOW_W-1:0] elapsed;
      logic        up;
      rpt = '0;
      case (cmd.opcode) inside
         OP_TICK: begin
            if (second_q == SEC_MAX) begin
               second_q = '0;
               if (minute_q == MIN_MAX) begin
                  minute_q = '0;
                  hour_q = (hour_q == HOUR_MAX) ? '0 : hour_q + 1'b1;
               end else begin
                  minute_q = minute_q + 1'b1;
               end
            end else begin
               second_q = second_q + 1'b1;
            end
         end
         OP_NEXT: field_q = field_q + 1'b1;
         OP_INC, OP_DEC: begin
            up = (cmd.opcode == OP_INC);
            if (cmd.editing) begin
               case (field_q)
                  FLD_HOURS: begin
                     if (up) hour_q = (hour_q == HOUR_MAX) ? '0 : hour_q + 1'b1;
                     else    hour_q = (hour_q == '0) ? HOUR_MAX : hour_q - 1'b1;
                  end
                  FLD_MINUTES: begin
                     if (up) minute_q = (minute_q == MIN_MAX) ? '0 : minute_q + 1'b1;
                     else    minute_q = (minute_q == '0) ? MIN_MAX : minute_q - 1'b1;
                  end
                  FLD_SECONDS: begin
                     if (up) second_q = (second_q == SEC_MAX) ? '0 : second_q + 1'b1;
                     else    second_q = (second_q == '0) ? SEC_MAX : second_q - 1'b1;
                  end
                  default: begin
                     // noon wraps to midnight, afternoon drops back by half a day
                     if (hour_q == HALF_DAY)     hour_q = '0;
                     else if (hour_q < HALF_DAY) hour_q = hour_q + HALF_DAY;
                     else                        hour_q = hour_q - HALF_DAY;
                  end
               endcase
            end
         end
         OP_DISPLAY: begin
            if (cmd.editing) begin
               elapsed = cmd.now_ms - last_toggle_q;
               if (elapsed > {{(NOW_W-INTERVAL_W){1'b0}}, interval_q}) begin
                  blink_q = ~blink_q;
                  last_toggle_q = cmd.now_ms;
                  toggles_seen++;
               end
               if (blink_q && field_q != FLD_AMPM) rpt.blank_field = field_q + 1'b1;
            end
         end
         default: ;
      endcase
      rpt.hours_out   = hour_q;
      rpt.minutes_out = minute_q;
      rpt.seconds_out = second_q;
      rpt.day_seconds = SEC_PER_HOUR * hour_q + SEC_PER_MIN * minute_q + second_q;
      rpt.blink_phase = blink_q;
      rpt.edit_field  = field_q;
      return rpt;
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
         error_count++;
      end
   endfunction

   // Hold valid and payload until the transfer, then record the expected report.
   task automatic send_command(input logic [OPCODE_W-1:0] op, input logic ed,
                               input logic [NOW_W-1:0] now);
      req_type cmd;
      cmd.opcode  = op;
      cmd.editing = ed;
      cmd.now_ms  = now;
      req_if.valid   <= 1'b1;
      req_if.payload <= cmd;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      expected_reports.push_back(predict_time_report(cmd));
      commands_sent++;
   endtask

   task automatic pause_sender(input int unsigned cycles);
      req_if.valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic drain_reports();
      req_if.valid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
   endtask

   task automatic write_interval(input logic [INTERVAL_W-1:0] value);
      drain_reports();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we     <= 1'b0;
      interval_q  = value;
      settings_used++;
   endtask

   task automatic test_reset_state();
      send_command(OP_DISPLAY, 1'b0, '0);
      send_command(OP_DISPLAY, 1'b1, '0);
      send_command(OP_INC, 1'b0, '1);
   endtask

   task automatic test_field_edits();
      send_command(OP_DEC, 1'b1, '0);
      send_command(OP_NEXT, 1'b0, '0);
      send_command(OP_DEC, 1'b1, '0);
      send_command(OP_NEXT, 1'b1, '0);
      send_command(OP_DEC, 1'b1, '0);
      send_command(OP_INC, 1'b1, '0);
      send_command(OP_DEC, 1'b1, '0);
   endtask

   task automatic test_day_wrap();
      // 23:59:59 rolls over to midnight
      send_command(OP_TICK, 1'b0, '0);
   endtask

   task automatic test_half_day_swap();
      send_command(OP_NEXT, 1'b1, '0);
      send_command(OP_INC, 1'b1, '0);
      send_command(OP_INC, 1'b1, '0);
      send_command(OP_DEC, 1'b1, '0);
      send_command(OP_INC, 1'b0, '0);
   endtask

   task automatic test_blink_window();
      send_command(OP_DISPLAY, 1'b1, '1);
      // after the wrap the elapsed time equals the interval: no toggle
      send_command(OP_DISPLAY, 1'b1, NOW_W'(BLINK_INTERVAL_RESET) - 1'b1);
      send_command(OP_DISPLAY, 1'b1, NOW_W'(BLINK_INTERVAL_RESET));
      send_command(OP_NEXT, 1'b1, '0);
      send_command(OP_DISPLAY, 1'b1, NOW_W'(BLINK_INTERVAL_RESET));
      send_command(OP_DISPLAY, 1'b0, '0);
   endtask

   task automatic test_spare_opcodes();
      for (int unsigned op = OP_DISPLAY + 1; op <= OPCODE_TOP; op++)
         send_command(OPCODE_W'(op), 1'b1, '1);
   endtask

   task automatic test_random_traffic(input logic [INTERVAL_W-1:0] interval,
                                      input int unsigned count, input bit with_gaps);
      int unsigned      useful;
      int unsigned      burst_left;
      int unsigned      r;
      bit               paused;
      logic [OPCODE_W-1:0] op;
      logic             ed;
      logic [NOW_W-1:0] now;
      useful     = 0;
      paused     = 1'b0;
      burst_left = $urandom_range(1, 24);
      write_interval(interval);
      while (useful < count) begin
         if ($urandom_range(0, 24) == 0) in_session = !in_session;
         r = $urandom_range(0, 99);
         if (in_session) begin
            op = (r < 5)  ? OP_TICK : (r < 20) ? OP_NEXT : (r < 45) ? OP_INC :
                 (r < 70) ? OP_DEC  : (r < 95) ? OP_DISPLAY :
                 OPCODE_W'($urandom_range(OP_DISPLAY + 1, OPCODE_TOP));
         end else begin
            op = (r < 50) ? OP_TICK : (r < 55) ? OP_NEXT : (r < 65) ? OP_INC :
                 (r < 70) ? OP_DEC  : (r < 95) ? OP_DISPLAY :
                 OPCODE_W'($urandom_range(OP_DISPLAY + 1, OPCODE_TOP));
         end
         ed = in_session ^ ($urandom_range(0, 15) == 0);
         // aim at both sides of the blink window as well as plain wall time
         case ($urandom_range(0, 9))
            0: now = $urandom;
            1: now = last_toggle_q + interval_q;
            2: now = last_toggle_q + interval_q + 1;
            3: now = last_toggle_q - $urandom_range(1, 3);
            default: begin
               wall_ms = wall_ms + $urandom_range(0, 2 * interval_q + 2);
               now = wall_ms;
            end
         endcase
         if (!(op > OP_DISPLAY || ((op == OP_INC || op == OP_DEC) && !ed))) useful++;
         send_command(op, ed, now);
         if (!paused && useful >= count / 2) begin
            paused = 1'b1;
            drain_reports();
         end
         if (with_gaps) begin
            burst_left--;
            if (burst_left == 0) begin
               pause_sender($urandom_range(1, 10));
               burst_left = $urandom_range(1, 24);
            end
         end
      end
   endtask

   // Receiver: check each transfer, then pick the next ready by stall mode.
   rx_mode_type rx_mode    = RX_OPEN;
   int unsigned stall_left = 0;
   logic [6:0]  rx_cycle   = '0;

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_reports.size() == 0) begin
            $display("%0t: report with nothing outstanding: expected none, actual %h",
                     $time, rsp_if.payload);
            error_count++;
         end else begin
            want_report = expected_reports.pop_front();
            check_field("hours_out",   want_report.hours_out,   rsp_if.payload.hours_out);
            check_field("minutes_out", want_report.minutes_out, rsp_if.payload.minutes_out);
            check_field("seconds_out", want_report.seconds_out, rsp_if.payload.seconds_out);
            check_field("day_seconds", want_report.day_seconds, rsp_if.payload.day_seconds);
            check_field("blank_field", want_report.blank_field, rsp_if.payload.blank_field);
            check_field("blink_phase", want_report.blink_phase, rsp_if.payload.blink_phase);
            check_field("edit_field",  want_report.edit_field,  rsp_if.payload.edit_field);
            reports_checked++;
         end
      end
      rx_cycle <= rx_cycle + 1'b1;
      if (rx_cycle == '0) rx_mode <= rx_mode_type'($urandom_range(0, 2));
      if (stall_left != 0) begin
         stall_left   <= stall_left - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         case (rx_mode)
            RX_OPEN:   rsp_if.ready <= 1'b1;
            RX_SPOTTY: rsp_if.ready <= ($urandom_range(0, 2) != 0);
            default: begin
               rsp_if.ready <= 1'b1;
               if ($urandom_range(0, 7) == 0) stall_left <= $urandom_range(1, 12);
            end
         endcase
      end
   end

   // Watchdog: drop the run if no transfer happens for too long.
   int unsigned idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
         $display("settable_time_of_day_clock regression: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      rsp_if.ready   = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_state();
      test_field_edits();
      test_day_wrap();
      test_half_day_swap();
      test_blink_window();
      test_spare_opcodes();
      test_random_traffic('0, 325, 1'b1);
      test_random_traffic('1, 325, 1'b1);
      test_random_traffic(INTERVAL_W'($urandom_range(1, 2000)), 325, 1'b0);
      test_random_traffic(BLINK_INTERVAL_RESET, 325, 1'b1);

      drain_reports();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Sent %0d commands and checked %0d reports across %0d blink intervals,",
               commands_sent, reports_checked, settings_used);
      $display("with %0d blink toggles and %0d mismatches.", toggles_seen, error_count);
      if (error_count == 0 && expected_reports.size() == 0) begin
         $display("settable_time_of_day_clock regression: pass");
      end else begin
         $display("settable_time_of_day_clock regression: fail");
      end
      $finish;
   end

endmodule
